/* rtl/rnra_pkg.sv */
// Package for the ring neighbor resource arbiter.
// Holds the request/response payload types, mode codes and shared-unit opcodes.
// No dependencies.
package rnra_pkg;

   // Request modes
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_REQUEST = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // Fixed field widths
   localparam int SEAT_W  = 3;
   localparam int TICK_W  = 32;
   localparam int MEAL_W  = 16;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [SEAT_W-1:0] seat;
   } req_type;

   typedef struct packed {
      logic [SEAT_W-1:0] granted_seat;
      logic [TICK_W-1:0] wait_ticks;
      logic [MEAL_W-1:0] meal_count;
      logic [TICK_W-1:0] total_wait;
      logic              last;
   } rsp_type;

endpackage

/* rtl/rnra_addsub.sv */
// Shared 32-bit add/subtract unit of the ring neighbor resource arbiter.
// Depends on rnra_pkg for the opcode type and widths.
module rnra_addsub (
   input  rnra_pkg::alu_op_type          op,
   input  logic [rnra_pkg::TICK_W-1:0]   a,
   input  logic [rnra_pkg::TICK_W-1:0]   b,
   output logic [rnra_pkg::TICK_W-1:0]   result,
   output logic                          carry
);

   logic                          sub;
   logic [rnra_pkg::TICK_W-1:0]   b_eff;
   logic [rnra_pkg::TICK_W:0]     full;

   assign sub    = (op == rnra_pkg::ALU_SUB);
   assign b_eff  = b ^ {rnra_pkg::TICK_W{sub}};
   assign full   = {1'b0, a} + {1'b0, b_eff} + {{rnra_pkg::TICK_W{1'b0}}, sub};
   assign result = full[rnra_pkg::TICK_W-1:0];
   assign carry  = full[rnra_pkg::TICK_W];

endmodule

/* rtl/ring_neighbour_resource_arbiter_top.sv */
// Top level of the ring neighbor resource arbiter: sequencer, seat stores, output register.
// Depends on rnra_pkg and rnra_addsub.
//
// SEATS clients sit in a ring; each shares one resource with each neighbor. A request
// (mode 1) makes a seat hungry, stamps it with the current tick count and grants it at
// once if neither neighbor eats. A release (mode 2) returns the seat to thinking and then
// re-tests the left neighbor, then the right one, so it can cause up to two grants. A tick
// (mode 0) advances the 32-bit tick counter; mode 3 and seats at or above SEATS are
// dropped without a response. Each grant returns one response with the seat, its wait in
// ticks, its saturating meal count and its saturating total wait; last marks the final
// grant of a request. Every response is built by one shared 32-bit add/subtract
// unit that first forms the wait (tick minus stamp) and then the saturating total, so a
// grant passes through the sequencer steps test, subtract and accumulate.
// req_ready is high only while the sequencer is idle. A finished response sits in an
// output register, so the block takes the next request while it waits.
module ring_neighbour_resource_arbiter_top #(
   parameter int SEATS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rnra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rnra_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(SEATS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TEST  = 5'b00010,
      ST_CALC  = 5'b00100,
      ST_SUM   = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   // Sequencer and datapath registers
   state_type                            state_ff, state_in;
   logic [rnra_pkg::TICK_W-1:0]          tick_ff, tick_in;
   logic [IW-1:0]                        cand_ff, cand_in;
   logic [IW-1:0]                        cand2_ff, cand2_in;
   logic                                 pend2_ff, pend2_in;
   logic [rnra_pkg::TICK_W-1:0]          wait_ff, wait_in;
   rnra_pkg::rsp_type                    hold_ff, hold_in;
   logic                                 hold_valid_ff, hold_valid_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   rnra_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   // Seat status: hungry and eating flags, thinking when both are low
   logic [SEATS-1:0]                     hungry_ff, hungry_in;
   logic [SEATS-1:0]                     eating_ff, eating_in;

   // Per-seat stores
   logic [rnra_pkg::TICK_W-1:0]          stamp_ff [SEATS];
   logic [rnra_pkg::MEAL_W-1:0]          meals_ff [SEATS];
   logic [rnra_pkg::TICK_W-1:0]          wsum_ff  [SEATS];

   logic                                 stamp_we;
   logic                                 acc_we;
   logic [IW-1:0]                        req_idx;
   logic [IW-1:0]                        req_left;
   logic [IW-1:0]                        req_right;
   logic                                 seat_ok;
   logic                                 req_fire;
   logic                                 slot_free;
   logic [SEATS-1:0]                     can_grant;

   rnra_pkg::alu_op_type                 alu_op;
   logic [rnra_pkg::TICK_W-1:0]          alu_a;
   logic [rnra_pkg::TICK_W-1:0]          alu_b;
   logic [rnra_pkg::TICK_W-1:0]          alu_sum;
   logic                                 alu_carry;
   logic [rnra_pkg::TICK_W-1:0]          total_new;
   logic [rnra_pkg::MEAL_W-1:0]          meals_new;

   // A seat may eat when it is hungry and neither neighbor eats
   for (genvar i = 0; i < SEATS; i++) begin : g_seat
      localparam int L = (i + SEATS - 1) % SEATS;
      localparam int R = (i + 1) % SEATS;
      assign can_grant[i] = hungry_ff[i] & ~eating_ff[L] & ~eating_ff[R];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign seat_ok   = ({2'b00, req_data.seat} < 5'(SEATS));
   assign req_idx   = IW'(req_data.seat);
   assign req_left  = (req_idx == '0) ? IW'(SEATS - 1) : req_idx - IW'(1);
   assign req_right = (req_idx == IW'(SEATS - 1)) ? '0 : req_idx + IW'(1);
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // Shared unit: subtract for the wait, add for the running total
   assign alu_op = (state_ff == ST_SUM) ? rnra_pkg::ALU_ADD : rnra_pkg::ALU_SUB;
   assign alu_a  = (state_ff == ST_SUM) ? wsum_ff[cand_ff] : tick_ff;
   assign alu_b  = (state_ff == ST_SUM) ? wait_ff : stamp_ff[cand_ff];

   rnra_addsub u_addsub (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_sum),
      .carry  (alu_carry)
   );

   // Saturate the total on carry out and hold the meal count at its maximum
   assign total_new = alu_carry ? '1 : alu_sum;
   assign meals_new = (&meals_ff[cand_ff]) ? meals_ff[cand_ff]
                                           : meals_ff[cand_ff] + rnra_pkg::MEAL_W'(1);

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      cand_in       = cand_ff;
      cand2_in      = cand2_ff;
      pend2_in      = pend2_ff;
      wait_in       = wait_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      hungry_in     = hungry_ff;
      eating_in     = eating_ff;
      stamp_we      = 1'b0;
      acc_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  rnra_pkg::MODE_TICK: begin
                     tick_in = tick_ff + rnra_pkg::TICK_W'(1);
                  end
                  rnra_pkg::MODE_REQUEST: begin
                     if (seat_ok) begin
                        hungry_in[req_idx] = 1'b1;
                        eating_in[req_idx] = 1'b0;
                        stamp_we           = 1'b1;
                        cand_in            = req_idx;
                        pend2_in           = 1'b0;
                        state_in           = ST_TEST;
                     end
                  end
                  rnra_pkg::MODE_RELEASE: begin
                     if (seat_ok) begin
                        hungry_in[req_idx] = 1'b0;
                        eating_in[req_idx] = 1'b0;
                        cand_in            = req_left;
                        cand2_in           = req_right;
                        pend2_in           = 1'b1;
                        state_in           = ST_TEST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TEST: begin
            if (can_grant[cand_ff]) begin
               // An earlier grant of this request goes out first, not marked last
               if (!hold_valid_ff || slot_free) begin
                  if (hold_valid_ff) begin
                     rsp_data_in   = hold_ff;
                     rsp_valid_in  = 1'b1;
                     hold_valid_in = 1'b0;
                  end
                  eating_in[cand_ff] = 1'b1;
                  hungry_in[cand_ff] = 1'b0;
                  state_in           = ST_CALC;
               end
            end else if (pend2_ff) begin
               cand_in  = cand2_ff;
               pend2_in = 1'b0;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_CALC: begin
            wait_in  = alu_sum;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_we                = 1'b1;
            hold_in.granted_seat  = rnra_pkg::SEAT_W'(cand_ff);
            hold_in.wait_ticks    = wait_ff;
            hold_in.meal_count    = meals_new;
            hold_in.total_wait    = total_new;
            hold_in.last          = 1'b0;
            hold_valid_in         = 1'b1;
            if (pend2_ff) begin
               cand_in  = cand2_ff;
               pend2_in = 1'b0;
               state_in = ST_TEST;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_data_in      = hold_ff;
               rsp_data_in.last = 1'b1;
               rsp_valid_in     = 1'b1;
               hold_valid_in    = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         pend2_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hungry_ff     <= '0;
         eating_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         pend2_ff      <= pend2_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hungry_ff     <= hungry_in;
         eating_ff     <= eating_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      cand2_ff    <= cand2_in;
      wait_ff     <= wait_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Request stamps are only read after a request has written them
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_ff[req_idx] <= tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meals_ff <= '{default: '0};
         wsum_ff  <= '{default: '0};
      end else if (acc_we) begin
         meals_ff[cand_ff] <= meals_new;
         wsum_ff[cand_ff]  <= total_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/rnra_checker.sv */
// Port-level checker for the ring neighbor resource arbiter, with its bind.
// Depends on rnra_pkg and ring_neighbour_resource_arbiter_top.
module rnra_checker #(
   parameter int SEATS = 5
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input rnra_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rnra_pkg::rsp_type rsp_data
);

   // A tick never occupies the sequencer
   a_tick_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == rnra_pkg::MODE_TICK |=> req_ready)
      else $error("not ready after a tick request");

   // An in-range request always starts a grant test
   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == rnra_pkg::MODE_REQUEST &&
      ({2'b00, req_data.seat} < 5'(SEATS)) |=> !req_ready)
      else $error("in-range request did not occupy the sequencer");

   // Every grant counts at least one meal
   a_meal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.meal_count != '0)
      else $error("grant with zero meal count");

   // On the first meal the saturating total equals the wait
   a_first_meal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.meal_count == 16'd1 |-> rsp_data.total_wait == rsp_data.wait_ticks)
      else $error("first meal total differs from its wait");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind ring_neighbour_resource_arbiter_top rnra_checker #(.SEATS(SEATS)) u_rnra_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
